/* rtl/irpd_pkg.sv */
package irpd_pkg;

  localparam int unsigned DurW    = 15;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegHdrMark   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHdrSpace  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBitMark   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneSpace  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegZeroSpace = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRptMark   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRptSpace  = 3'd6;

  localparam logic [DurW-1:0] RstHdrMark   = 15'd3400;
  localparam logic [DurW-1:0] RstHdrSpace  = 15'd1750;
  localparam logic [DurW-1:0] RstBitMark   = 15'd340;
  localparam logic [DurW-1:0] RstOneSpace  = 15'd1300;
  localparam logic [DurW-1:0] RstZeroSpace = 15'd420;
  localparam logic [DurW-1:0] RstRptMark   = 15'd440;
  localparam logic [DurW-1:0] RstRptSpace  = 15'd17100;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       gap_after;
  } in_item_t;

  typedef struct packed {
    logic            line_level;
    logic [DurW-1:0] duration_us;
    logic            last_segment;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic       hdr;
    logic [7:0] data;
    logic       chk;
    logic [7:0] chk_byte;
    logic       trl;
  } cmd_t;

  typedef struct packed {
    logic [DurW-1:0] hdr_mark;
    logic [DurW-1:0] hdr_space;
    logic [DurW-1:0] bit_mark;
    logic [DurW-1:0] one_space;
    logic [DurW-1:0] zero_space;
    logic [DurW-1:0] rpt_mark;
    logic [DurW-1:0] rpt_space;
  } cfg_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

/* rtl/irpd_front.sv */
module irpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  irpd_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output irpd_pkg::cmd_t    q_cmd_o
);
  import irpd_pkg::*;

  logic [7:0] sum_q, sum_d;
  logic [7:0] sum_nxt;

  // The checksum covers the payload byte that closes the frame as well.
  assign sum_nxt  = sum_q + in_item_i.data_byte;
  assign q_push_o = push && !q_full_i;

  always_comb begin
    q_cmd_o.hdr      = in_item_i.first_of_frame;
    q_cmd_o.data     = in_item_i.data_byte;
    q_cmd_o.chk      = in_item_i.last_of_frame;
    q_cmd_o.chk_byte = sum_nxt;
    q_cmd_o.trl      = in_item_i.last_of_frame && in_item_i.gap_after;
  end

  always_comb begin
    sum_d = sum_q;
    if (q_push_o) begin
      sum_d = in_item_i.last_of_frame ? 8'd0 : sum_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 8'd0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

/* rtl/irpd_cmd_fifo.sv */
module irpd_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  irpd_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output irpd_pkg::cmd_head_t head_o
);
  import irpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/irpd_back.sv */
module irpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irpd_pkg::cfg_t      cfg_i,
  input  irpd_pkg::cmd_head_t head_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output irpd_pkg::out_item_t out_item_o
);
  import irpd_pkg::*;

  localparam logic [1:0] PhHdr  = 2'd0;
  localparam logic [1:0] PhData = 2'd1;
  localparam logic [1:0] PhChk  = 2'd2;
  localparam logic [1:0] PhTrl  = 2'd3;

  cmd_t       cur_q, cur_d;
  logic       busy_q, busy_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] seg_q, seg_d;
  logic       out_vld_q, out_vld_d;
  out_item_t  out_q, out_d;

  logic       adv, load, bit_val;
  out_item_t  seg;

  // A segment moves into the output register when it is free or being taken.
  assign adv     = busy_q && (!out_vld_q || pop);
  assign load    = head_i.valid && (!busy_q || (adv && seg.last_segment));
  assign q_pop_o = load;
  assign bit_val = (phase_q == PhChk) ? cur_q.chk_byte[seg_q[3:1]] : cur_q.data[seg_q[3:1]];

  // Even segment numbers are marks, odd ones are spaces.
  always_comb begin
    seg.line_level   = !seg_q[0];
    seg.duration_us  = '0;
    seg.last_segment = 1'b0;
    case (phase_q)
      PhHdr: begin
        seg.duration_us = seg_q[0] ? cfg_i.hdr_space : cfg_i.hdr_mark;
      end
      PhData: begin
        seg.duration_us  = !seg_q[0] ? cfg_i.bit_mark :
                           (bit_val ? cfg_i.one_space : cfg_i.zero_space);
        seg.last_segment = (seg_q == 4'd15) && !cur_q.chk;
      end
      PhChk: begin
        seg.duration_us  = !seg_q[0] ? cfg_i.bit_mark :
                           (bit_val ? cfg_i.one_space : cfg_i.zero_space);
        seg.last_segment = (seg_q == 4'd15) && !cur_q.trl;
      end
      PhTrl: begin
        seg.duration_us  = seg_q[0] ? cfg_i.rpt_space : cfg_i.rpt_mark;
        seg.last_segment = seg_q[0];
      end
      default: begin
        seg.duration_us = '0;
      end
    endcase
  end

  always_comb begin
    cur_d   = cur_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    seg_d   = seg_q;
    if (load) begin
      cur_d   = head_i.cmd;
      busy_d  = 1'b1;
      phase_d = head_i.cmd.hdr ? PhHdr : PhData;
      seg_d   = '0;
    end else if (adv && seg.last_segment) begin
      busy_d = 1'b0;
    end else if (adv) begin
      seg_d = seg_q + 1'b1;
      if ((phase_q == PhHdr) && seg_q[0]) begin
        phase_d = PhData;
        seg_d   = '0;
      end else if ((phase_q == PhData) && (seg_q == 4'd15)) begin
        phase_d = PhChk;
        seg_d   = '0;
      end else if ((phase_q == PhChk) && (seg_q == 4'd15)) begin
        phase_d = PhTrl;
        seg_d   = '0;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (adv) begin
      out_vld_d = 1'b1;
      out_d     = seg;
    end else if (pop && out_vld_q) begin
      out_vld_d = 1'b0;
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      phase_q   <= PhHdr;
      seg_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      phase_q   <= phase_d;
      seg_q     <= seg_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

endmodule

/* rtl/ir_pulse_distance_frame_encoder_core.sv */
// Infrared pulse-distance frame encoder. Each item pushed in is one payload
// byte; the block pops out line segments (level, duration in microseconds):
// an optional header mark and space, eight bit mark/space pairs sent LSB
// first, and on the last byte of a frame a checksum byte (the wrapping sum of
// the frame's bytes) and an optional repeat trailer. An item yields 16, 18,
// 32, 34 or 36 segments; the single output register passes one segment per
// clock while the receiver keeps pop high. The input side accepts one item
// per clock until the command queue of CmdDepth entries between the front
// and the segment sequencer fills. Duration registers are to be written
// through the configuration port while idle; the block does not enforce it.
module ir_pulse_distance_frame_encoder_core #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  irpd_pkg::in_item_t                in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output irpd_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [irpd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [irpd_pkg::DurW-1:0]         cfg_data_i
);
  import irpd_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      q_push, q_pop;
  cmd_t      q_cmd;
  cmd_head_t q_head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHdrMark:   cfg_d.hdr_mark   = cfg_data_i;
        RegHdrSpace:  cfg_d.hdr_space  = cfg_data_i;
        RegBitMark:   cfg_d.bit_mark   = cfg_data_i;
        RegOneSpace:  cfg_d.one_space  = cfg_data_i;
        RegZeroSpace: cfg_d.zero_space = cfg_data_i;
        RegRptMark:   cfg_d.rpt_mark   = cfg_data_i;
        RegRptSpace:  cfg_d.rpt_space  = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_mark   <= RstHdrMark;
      cfg_q.hdr_space  <= RstHdrSpace;
      cfg_q.bit_mark   <= RstBitMark;
      cfg_q.one_space  <= RstOneSpace;
      cfg_q.zero_space <= RstZeroSpace;
      cfg_q.rpt_mark   <= RstRptMark;
      cfg_q.rpt_space  <= RstRptSpace;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item_i),
    .q_full_i  (full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd)
  );

  irpd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .full_o (full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  irpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (q_head),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

/* rtl/irpd_checker.sv */
module irpd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input irpd_pkg::out_item_t out_item_o
);
  import irpd_pkg::*;

  logic       in_acc, out_acc;
  logic       seen_q;
  logic       prev_lvl_q;
  logic [7:0] pend_q;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      prev_lvl_q <= 1'b0;
      pend_q     <= '0;
    end else begin
      if (out_acc) begin
        seen_q     <= 1'b1;
        prev_lvl_q <= out_item_o.line_level;
      end
      pend_q <= pend_q + {7'd0, in_acc} - {7'd0, out_acc && out_item_o.last_segment};
    end
  end

  // A waiting result stays put until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result changed while waiting");

  // Marks and spaces always alternate on the line.
  a_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> out_item_o.line_level != prev_lvl_q)
    else $error("two segments of the same level in a row");

  // Every item ends on a space.
  a_last_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_item_o.last_segment |-> !out_item_o.line_level)
    else $error("item ends on a mark");

  // No segment appears without an item that is still owed results.
  a_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 8'd0)
    else $error("segment without an outstanding item");

endmodule

bind ir_pulse_distance_frame_encoder_core irpd_checker u_irpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

/* tb/ir_pulse_distance_frame_encoder_core_tb.sv */
`timescale 1ns / 100ps

module ir_pulse_distance_frame_encoder_core_tb;
  import irpd_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned SettleCycles = 12;
  localparam logic [DurW-1:0] DurMax = 15'h7fff;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  in_item_t          in_item_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  out_item_t         out_item_o;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DurW-1:0]   cfg_data_i = '0;

  // Shadow copy of the duration registers and of the running frame sum.
  logic [DurW-1:0] dur_reg [NumRegs];
  logic [7:0]      frame_sum;
  out_item_t       pending_segments[$];

  int errors = 0;
  int items_sent = 0;
  int frames_closed = 0;
  int segs_checked = 0;
  int reg_writes = 0;
  int full_stalls = 0;
  int hold_off_cycles = 0;
  int longest_hold = 0;
  int burst_left = 0;

  ir_pulse_distance_frame_encoder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Works out every segment that one accepted item must produce.
  function automatic void encode_item(in_item_t it);
    out_item_t  segs[$];
    out_item_t  seg;
    logic [7:0] tx_bytes[$];
    seg = '0;
    if (it.first_of_frame) begin
      seg.line_level  = 1'b1;
      seg.duration_us = dur_reg[RegHdrMark];
      segs.push_back(seg);
      seg.line_level  = 1'b0;
      seg.duration_us = dur_reg[RegHdrSpace];
      segs.push_back(seg);
    end
    frame_sum = frame_sum + it.data_byte;
    tx_bytes.push_back(it.data_byte);
    if (it.last_of_frame) tx_bytes.push_back(frame_sum);
    foreach (tx_bytes[k]) begin
      for (int i = 0; i < 8; i++) begin
        seg.line_level  = 1'b1;
        seg.duration_us = dur_reg[RegBitMark];
        segs.push_back(seg);
        seg.line_level  = 1'b0;
        seg.duration_us = tx_bytes[k][i] ? dur_reg[RegOneSpace] : dur_reg[RegZeroSpace];
        segs.push_back(seg);
      end
    end
    if (it.last_of_frame) begin
      if (it.gap_after) begin
        seg.line_level  = 1'b1;
        seg.duration_us = dur_reg[RegRptMark];
        segs.push_back(seg);
        seg.line_level  = 1'b0;
        seg.duration_us = dur_reg[RegRptSpace];
        segs.push_back(seg);
      end
      frame_sum = '0;
      frames_closed++;
    end
    seg = segs.pop_back();
    seg.last_segment = 1'b1;
    segs.push_back(seg);
    foreach (segs[i]) pending_segments.push_back(segs[i]);
  endfunction

  // Offers one item and returns once it has been accepted; push stays high.
  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    push      <= 1'b1;
    in_item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!full) break;
      full_stalls++;
    end
    encode_item(it);
    items_sent++;
  endtask

  task automatic idle_cycles(int n);
    logic [10:0] junk;
    for (int i = 0; i < n; i++) begin
      junk = 11'($urandom);
      @(negedge clk_i);
      push      <= 1'b0;
      in_item_i <= junk;
    end
  endtask

  task automatic send_paced(in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 8));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (pending_segments.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx < NumRegs) dur_reg[idx] = value;
    reg_writes++;
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(logic [DurW-1:0] value);
    for (int r = 0; r < NumRegs; r++) write_reg(CfgIdxW'(r), value);
  endtask

  function automatic in_item_t make_item(logic [7:0] data, logic first, logic last,
                                         logic gap);
    in_item_t it;
    it.data_byte      = data;
    it.first_of_frame = first;
    it.last_of_frame  = last;
    it.gap_after      = gap;
    return it;
  endfunction

  task automatic test_directed_frames();
    send_item(make_item(8'h00, 1'b1, 1'b0, 1'b0));
    send_item(make_item(8'hff, 1'b0, 1'b0, 1'b0));
    // A trailer request without the last flag must be ignored.
    send_item(make_item(8'h5a, 1'b0, 1'b0, 1'b1));
    send_item(make_item(8'ha5, 1'b0, 1'b1, 1'b1));
    send_item(make_item(8'hff, 1'b1, 1'b1, 1'b0));
    send_item(make_item(8'h01, 1'b1, 1'b1, 1'b1));
    // A new header does not clear the sum; only a last byte does.
    send_item(make_item(8'h10, 1'b1, 1'b0, 1'b0));
    send_item(make_item(8'h20, 1'b1, 1'b0, 1'b0));
    send_item(make_item(8'h30, 1'b0, 1'b1, 1'b0));
    // The sum wraps at eight bits.
    send_item(make_item(8'hff, 1'b1, 1'b0, 1'b0));
    send_item(make_item(8'hff, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h80, 1'b0, 1'b1, 1'b1));
    send_item(make_item(8'h3c, 1'b0, 1'b1, 1'b0));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_all_regs(DurMax);
    write_reg(RegUnused, 15'h1234);
    end_writes();
    send_item(make_item(8'hc3, 1'b1, 1'b1, 1'b1));
    wait_drained();
    write_all_regs(15'd1);
    end_writes();
    send_item(make_item(8'h3c, 1'b1, 1'b1, 1'b1));
    wait_drained();
    // Zero durations lie outside the legal range but must pass straight through.
    write_all_regs('0);
    write_reg(RegUnused, DurMax);
    end_writes();
    send_item(make_item(8'h96, 1'b1, 1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 400;
    for (int i = 0; i < 10; i++)
      send_item(make_item(8'($urandom), i == 0, i == 9, 1'b1));
    wait_drained();
  endtask

  task automatic test_random_frames(int n_items);
    int         done;
    int         frame_len;
    int         pause_at;
    in_item_t   it;
    logic [DurW-1:0] value;
    done     = 0;
    pause_at = $urandom_range(10, n_items - 10);
    for (int r = 0; r < NumRegs; r++) begin
      case ($urandom_range(9))
        0:       value = 15'd1;
        1:       value = DurMax;
        2:       value = '0;
        default: value = 15'($urandom_range(1, 32767));
      endcase
      write_reg(CfgIdxW'(r), value);
    end
    if ($urandom_range(1)) write_reg(RegUnused, 15'($urandom));
    end_writes();
    while (done < n_items) begin
      if ($urandom_range(99) < 15) begin
        it = in_item_t'(11'($urandom));
        send_paced(it);
        done++;
      end else begin
        frame_len = $urandom_range(1, 6);
        for (int k = 0; k < frame_len && done < n_items; k++) begin
          it.data_byte      = 8'($urandom);
          it.first_of_frame = (k == 0);
          it.last_of_frame  = (k == frame_len - 1);
          it.gap_after      = 1'($urandom);
          send_paced(it);
          done++;
        end
      end
      if (done >= pause_at && pause_at > 0) begin
        wait_drained();
        pause_at = 0;
      end
    end
    wait_drained();
  endtask

  // Receiver: runs of differing stall density, plus long hold-offs on request.
  initial begin
    int run_left;
    int stall_pct;
    run_left  = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        if (hold_off_cycles > longest_hold) longest_hold = hold_off_cycles;
        pop <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 85;
          endcase
          run_left = $urandom_range(4, 40);
        end
        pop <= ($urandom_range(99) >= stall_pct);
        run_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_segments.size() == 0) begin
        $error("unexpected segment: line_level %0d, duration_us %0d, last_segment %0d",
               out_item_o.line_level, out_item_o.duration_us, out_item_o.last_segment);
        errors++;
      end else begin
        want = pending_segments.pop_front();
        segs_checked++;
        if (out_item_o.line_level !== want.line_level) begin
          $error("line_level mismatch: expected %0d, got %0d",
                 want.line_level, out_item_o.line_level);
          errors++;
        end
        if (out_item_o.duration_us !== want.duration_us) begin
          $error("duration_us mismatch: expected %0d, got %0d",
                 want.duration_us, out_item_o.duration_us);
          errors++;
        end
        if (out_item_o.last_segment !== want.last_segment) begin
          $error("last_segment mismatch: expected %0d, got %0d",
                 want.last_segment, out_item_o.last_segment);
          errors++;
        end
      end
    end
  end

  initial begin
    dur_reg[RegHdrMark]   = RstHdrMark;
    dur_reg[RegHdrSpace]  = RstHdrSpace;
    dur_reg[RegBitMark]   = RstBitMark;
    dur_reg[RegOneSpace]  = RstOneSpace;
    dur_reg[RegZeroSpace] = RstZeroSpace;
    dur_reg[RegRptMark]   = RstRptMark;
    dur_reg[RegRptSpace]  = RstRptSpace;
    frame_sum = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    test_directed_frames();
    test_register_extremes();
    test_backpressure();
    for (int p = 0; p < 4; p++) test_random_frames(96);

    if (pending_segments.size() != 0) begin
      $error("%0d expected segments never arrived", pending_segments.size());
      errors++;
    end
    $display("Covered %0d items in %0d closed frames, %0d segments checked, %0d register writes.",
             items_sent, frames_closed, segs_checked, reg_writes);
    $display("Input was held off by a full queue on %0d cycles; longest output hold %0d cycles.",
             full_stalls, longest_hold);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/irpd_pkg.sv
rtl/irpd_front.sv
rtl/irpd_cmd_fifo.sv
rtl/irpd_back.sv
rtl/ir_pulse_distance_frame_encoder_core.sv
rtl/irpd_checker.sv
tb/ir_pulse_distance_frame_encoder_core_tb.sv
